### hw/rtl/vpb_pkg.sv
// ----------------------------------------------------------------------------
// vpb_pkg
// Shared types and constants of the voxel point binning block.
// ----------------------------------------------------------------------------
package vpb_pkg;

	localparam int COORD_W  = 16;
	localparam int HALF_W   = 15;
	localparam int SCALE_W  = 16;
	localparam int OP_W     = 2;
	localparam int VSEL_W   = 12;
	localparam int SSEL_W   = 4;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int OBS_W    = 3 * COORD_W;

	localparam logic [HALF_W-1:0]  HALF_RESET  = 15'd2560;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd205;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_STORED     = 3'd0,
		ST_OOB        = 3'd1,
		ST_FULL       = 3'd2,
		ST_CLEARED    = 3'd3,
		ST_READ_OK    = 3'd4,
		ST_READ_EMPTY = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HALF_X  = 3'd0,
		REG_HALF_Y  = 3'd1,
		REG_HALF_Z  = 3'd2,
		REG_SCALE_X = 3'd3,
		REG_SCALE_Y = 3'd4,
		REG_SCALE_Z = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_LIN,
		S_CRD,
		S_UPD,
		S_OFIN,
		S_RRD,
		S_RFIN,
		S_CLR,
		S_CFIN
	} state_t;

endpackage

### hw/rtl/vpb_in_if.sv
// ----------------------------------------------------------------------------
// vpb_in_if
// Command channel: operation, point coordinates and read selection.
// ----------------------------------------------------------------------------
interface vpb_in_if import vpb_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           operation;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic signed [COORD_W-1:0] coord_z;
	logic [VSEL_W-1:0]         voxel_select;
	logic [SSEL_W-1:0]         slot_select;

	modport source (
		output valid, operation, coord_x, coord_y, coord_z, voxel_select, slot_select,
		input  ready
	);
	modport sink (
		input  valid, operation, coord_x, coord_y, coord_z, voxel_select, slot_select,
		output ready
	);
endinterface

### hw/rtl/vpb_out_if.sv
// ----------------------------------------------------------------------------
// vpb_out_if
// Result channel: status, voxel and slot, count and observation.
// ----------------------------------------------------------------------------
interface vpb_out_if import vpb_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic [VSEL_W-1:0]         voxel_index;
	logic [SSEL_W-1:0]         slot_index;
	logic [CNT_W-1:0]          point_count;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic signed [COORD_W-1:0] out_z;

	modport source (
		output valid, status, voxel_index, slot_index, point_count, out_x, out_y, out_z,
		input  ready
	);
	modport sink (
		input  valid, status, voxel_index, slot_index, point_count, out_x, out_y, out_z,
		output ready
	);
endinterface

### hw/rtl/vpb_ram.sv
// ----------------------------------------------------------------------------
// vpb_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module vpb_ram #(
	parameter int     WIDTH = 8,
	parameter longint DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/vpb_axis.sv
// ----------------------------------------------------------------------------
// vpb_axis
// One axis: bounds check, offset, scale multiply and clamp to the last cell.
// ----------------------------------------------------------------------------
module vpb_axis import vpb_pkg::*; #(
	parameter int CELLS = 16
) (
	input  logic                      clk,
	input  logic                      load,
	input  logic                      mul_en,
	input  logic signed [COORD_W-1:0] coord,
	input  logic [HALF_W-1:0]         half,
	input  logic [SCALE_W-1:0]        scale,
	output logic                      oob,
	output logic [((CELLS > 1) ? $clog2(CELLS) : 1)-1:0] cell_idx
);

	localparam int CW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam logic [COORD_W-1:0] LAST = COORD_W'(CELLS - 1);

	logic signed [COORD_W:0] c_ext;
	logic signed [COORD_W:0] h_ext;
	logic signed [COORD_W:0] sum;
	logic                    oob_d;

	logic [COORD_W-1:0]      shifted_s1;
	logic                    oob_s1;
	logic [2*COORD_W-1:0]    prod;
	logic [COORD_W-1:0]      raw_s2;

	assign c_ext = $signed({coord[COORD_W-1], coord});
	assign h_ext = $signed({2'b00, half});
	assign sum   = c_ext + h_ext;
	assign oob_d = sum[COORD_W] | (c_ext > h_ext);

	always_ff @(posedge clk) begin
		if (load) begin
			shifted_s1 <= sum[COORD_W-1:0];
			oob_s1     <= oob_d;
		end
	end

	assign prod = shifted_s1 * scale;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			raw_s2 <= prod[2*COORD_W-1:COORD_W];
		end
	end

	assign oob      = oob_s1;
	assign cell_idx = (raw_s2 >= LAST) ? CW'(LAST) : CW'(raw_s2);

endmodule

### hw/rtl/voxel_point_binning.sv
// ----------------------------------------------------------------------------
// voxel_point_binning
// Bins Q8.8 points into a voxel grid and keeps per-voxel observation lists.
// ----------------------------------------------------------------------------
// One item is in work at a time; the result sits in an output register, so
// the next item is taken while it waits. An add runs offset, multiply,
// linearize, count read, and count and store write; a point out of bounds
// skips the last three. A read is a single memory read. A clear sweeps the
// count memory one voxel per cycle, set by the single write port of the
// count memory. After reset the same sweep runs before the first transfer;
// configuration writes are taken throughout.
module voxel_point_binning import vpb_pkg::*; #(
	parameter int CELLS_X = 16,
	parameter int CELLS_Y = 16,
	parameter int CELLS_Z = 16,
	parameter int MAX_OBS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	vpb_in_if.sink                in_ch,
	vpb_out_if.source             out_ch
);

	localparam int     NVOX = CELLS_X * CELLS_Y * CELLS_Z;
	localparam int     VW   = (NVOX > 1) ? $clog2(NVOX) : 1;
	localparam int     CW   = $clog2(MAX_OBS);
	localparam int     SW   = $clog2(MAX_OBS);
	localparam longint SDEPTH = longint'(NVOX) * (longint'(1) << SW);
	localparam int     XW   = (CELLS_X > 1) ? $clog2(CELLS_X) : 1;
	localparam int     YW   = (CELLS_Y > 1) ? $clog2(CELLS_Y) : 1;
	localparam int     ZW   = (CELLS_Z > 1) ? $clog2(CELLS_Z) : 1;
	localparam int     STRIDE_I = CELLS_Y * CELLS_Z;

	// configuration
	logic [HALF_W-1:0]  half_x_q, half_y_q, half_z_q;
	logic [SCALE_W-1:0] scale_x_q, scale_y_q, scale_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_x_q  <= HALF_RESET;
			half_y_q  <= HALF_RESET;
			half_z_q  <= HALF_RESET;
			scale_x_q <= SCALE_RESET;
			scale_y_q <= SCALE_RESET;
			scale_z_q <= SCALE_RESET;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_HALF_X:  half_x_q  <= cfg_data[HALF_W-1:0];
				REG_HALF_Y:  half_y_q  <= cfg_data[HALF_W-1:0];
				REG_HALF_Z:  half_z_q  <= cfg_data[HALF_W-1:0];
				REG_SCALE_X: scale_x_q <= cfg_data;
				REG_SCALE_Y: scale_y_q <= cfg_data;
				REG_SCALE_Z: scale_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control
	state_t state_q, state_d;

	logic in_xfer;
	logic out_free;
	logic emit;
	logic load;
	logic mul_en;
	logic oob;
	op_t  op_in;

	logic [XW-1:0] cell_x;
	logic [YW-1:0] cell_y;
	logic [ZW-1:0] cell_z;
	logic          oob_x, oob_y, oob_z;

	logic [VSEL_W-1:0]         vsel_q;
	logic [SSEL_W-1:0]         ssel_q;
	logic signed [COORD_W-1:0] px_q, py_q, pz_q;
	logic [VW-1:0]             vox_q;
	logic [VW-1:0]             vox_lin;
	logic [VW-1:0]             clr_cnt_q;
	logic                      clr_emit_q;

	// memories
	logic          cnt_we;
	logic [VW-1:0] cnt_waddr, cnt_raddr;
	logic [CW-1:0] cnt_wdata, cnt_rdata;
	logic          obs_we;
	logic [VW+SW-1:0] obs_waddr, obs_raddr;
	logic [OBS_W-1:0] obs_rdata;

	logic          full;
	logic          vin;
	logic          hit;

	// result register
	logic                      out_valid_q;
	status_t                   status_q;
	logic [VSEL_W-1:0]         vidx_q;
	logic [SSEL_W-1:0]         slot_q;
	logic [CNT_W-1:0]          count_q;
	logic signed [COORD_W-1:0] ox_q, oy_q, oz_q;

	assign op_in    = op_t'(in_ch.operation);
	assign in_xfer  = in_ch.valid & in_ch.ready;
	assign out_free = ~out_valid_q | out_ch.ready;
	assign oob      = oob_x | oob_y | oob_z;

	vpb_axis #(.CELLS(CELLS_X)) u_axis_x (
		.clk(clk), .load(load), .mul_en(mul_en), .coord(in_ch.coord_x),
		.half(half_x_q), .scale(scale_x_q), .oob(oob_x), .cell_idx(cell_x)
	);
	vpb_axis #(.CELLS(CELLS_Y)) u_axis_y (
		.clk(clk), .load(load), .mul_en(mul_en), .coord(in_ch.coord_y),
		.half(half_y_q), .scale(scale_y_q), .oob(oob_y), .cell_idx(cell_y)
	);
	vpb_axis #(.CELLS(CELLS_Z)) u_axis_z (
		.clk(clk), .load(load), .mul_en(mul_en), .coord(in_ch.coord_z),
		.half(half_z_q), .scale(scale_z_q), .oob(oob_z), .cell_idx(cell_z)
	);

	assign vox_lin = VW'(32'(cell_x) * 32'(STRIDE_I) + 32'(cell_y) * 32'(CELLS_Z)
		+ 32'(cell_z));

	assign full = 9'(cnt_rdata) >= 9'(MAX_OBS - 1);
	assign vin  = 32'(vsel_q) < 32'(NVOX);
	assign hit  = vin & (9'(ssel_q) < 9'(cnt_rdata));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					case (op_in)
						OP_ADD:   state_d = S_MUL;
						OP_CLEAR: state_d = S_CLR;
						default:  state_d = S_RRD;
					endcase
				end
			end
			S_MUL:  state_d = oob ? S_OFIN : S_LIN;
			S_LIN:  state_d = S_CRD;
			S_CRD:  state_d = S_UPD;
			S_RRD:  state_d = S_RFIN;
			S_CLR: begin
				if (clr_cnt_q == VW'(NVOX - 1)) begin
					state_d = clr_emit_q ? S_CFIN : S_IDLE;
				end
			end
			S_UPD, S_OFIN, S_RFIN, S_CFIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		in_ch.ready = 1'b0;
		load        = 1'b0;
		mul_en      = 1'b0;
		emit        = 1'b0;
		cnt_we      = 1'b0;
		cnt_waddr   = vox_q;
		cnt_wdata   = CW'(9'(cnt_rdata) + 9'd1);
		cnt_raddr   = vox_q;
		obs_we      = 1'b0;
		obs_waddr   = {vox_q, SW'(cnt_rdata)};
		obs_raddr   = {VW'(vsel_q), SW'(ssel_q)};
		case (state_q)
			S_IDLE: begin
				in_ch.ready = 1'b1;
				load        = in_xfer;
			end
			S_MUL: mul_en = 1'b1;
			S_RRD, S_RFIN: begin
				cnt_raddr = VW'(vsel_q);
				emit      = (state_q == S_RFIN) & out_free;
			end
			S_UPD: begin
				emit   = out_free;
				cnt_we = out_free & ~full;
				obs_we = out_free & ~full;
			end
			S_CLR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_cnt_q;
				cnt_wdata = '0;
			end
			S_OFIN, S_CFIN: emit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_cnt_q  <= '0;
			clr_emit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer && op_in == OP_CLEAR) begin
				clr_cnt_q  <= '0;
				clr_emit_q <= 1'b1;
			end else if (state_q == S_CLR) begin
				clr_cnt_q <= clr_cnt_q + VW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			vsel_q <= in_ch.voxel_select;
			ssel_q <= in_ch.slot_select;
			px_q   <= in_ch.coord_x;
			py_q   <= in_ch.coord_y;
			pz_q   <= in_ch.coord_z;
		end
		if (state_q == S_LIN) begin
			vox_q <= vox_lin;
		end
	end

	vpb_ram #(.WIDTH(CW), .DEPTH(longint'(NVOX))) u_count_ram (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	vpb_ram #(.WIDTH(OBS_W), .DEPTH(SDEPTH)) u_obs_ram (
		.clk(clk), .we(obs_we), .waddr(obs_waddr), .wdata({px_q, py_q, pz_q}),
		.raddr(obs_raddr), .rdata(obs_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= ST_CLEARED;
			vidx_q   <= '0;
			slot_q   <= '0;
			count_q  <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			oz_q     <= '0;
			case (state_q)
				S_OFIN: status_q <= ST_OOB;
				S_UPD: begin
					status_q <= full ? ST_FULL : ST_STORED;
					vidx_q   <= VSEL_W'(vox_q);
					slot_q   <= full ? '0 : SSEL_W'(cnt_rdata);
					count_q  <= full ? CNT_W'(cnt_rdata) : CNT_W'(9'(cnt_rdata) + 9'd1);
				end
				S_RFIN: begin
					status_q <= hit ? ST_READ_OK : ST_READ_EMPTY;
					vidx_q   <= vsel_q;
					slot_q   <= ssel_q;
					count_q  <= vin ? CNT_W'(cnt_rdata) : '0;
					if (hit) begin
						ox_q <= obs_rdata[3*COORD_W-1:2*COORD_W];
						oy_q <= obs_rdata[2*COORD_W-1:COORD_W];
						oz_q <= obs_rdata[COORD_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = status_q;
	assign out_ch.voxel_index = vidx_q;
	assign out_ch.slot_index  = slot_q;
	assign out_ch.point_count = count_q;
	assign out_ch.out_x       = ox_q;
	assign out_ch.out_y       = oy_q;
	assign out_ch.out_z       = oz_q;

endmodule

### test/voxel_point_binning_test.sv
// ----------------------------------------------------------------------------
// voxel_point_binning_test
// Self-checking bench for the voxel point binning block. A short table of
// hand-picked commands (boundaries, clamping, full voxel, clear, spare opcode)
// runs first, then several grid settings with random traffic clustered on a
// few hot voxels. Results are compared with table rows or a behavioral model.
// ----------------------------------------------------------------------------
module voxel_point_binning_test import vpb_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_X      = 16;
	localparam int GRID_Y      = 16;
	localparam int GRID_Z      = 16;
	localparam int MAX_POINTS  = 16;
	localparam int VOXELS      = GRID_X * GRID_Y * GRID_Z;
	localparam int HALF_MAX    = (1 << HALF_W) - 1;
	localparam int SCALE_MAX   = (1 << SCALE_W) - 1;
	localparam int HOT_SPOTS   = 4;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 240;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_CFG  = -1;

	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [VSEL_W-1:0]         vsel;
		logic [SSEL_W-1:0]         ssel;
	} bin_cmd_t;

	typedef struct packed {
		status_t                   status;
		logic [VSEL_W-1:0]         voxel;
		logic [SSEL_W-1:0]         slot;
		logic [CNT_W-1:0]          count;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} bin_result_t;

	typedef struct packed {
		bin_cmd_t    cmd;
		int          reps;
		bit          typed;
		bin_result_t want;
	} opening_row_t;

	localparam bin_result_t UNTYPED = '0;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	vpb_in_if  in_ch ();
	vpb_out_if out_ch ();

	voxel_point_binning #(
		.CELLS_X(GRID_X),
		.CELLS_Y(GRID_Y),
		.CELLS_Z(GRID_Z),
		.MAX_OBS(MAX_POINTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// binning model state
	logic [HALF_W-1:0]  half_ext [3];
	logic [SCALE_W-1:0] cell_scale [3];
	logic [CNT_W-1:0]   tally [VOXELS];
	logic [OBS_W-1:0]   obs_mem [VOXELS][MAX_POINTS];

	bin_result_t awaited_results [$];
	int          hit_voxels [$];
	int          hot_spot [HOT_SPOTS][3];
	int          mismatches = 0;
	int          hold_request = 0;
	bit          in_steady = 0;

	opening_row_t opening [16] = '{
		'{'{OP_READ, 16'sd0, 16'sd0, 16'sd0, 12'd0, 4'd0}, 1, 1'b1,
			'{ST_READ_EMPTY, 12'd0, 4'd0, 4'd0, 16'sd0, 16'sd0, 16'sd0}},
		'{'{OP_ADD, 16'sd2560, 16'sd2560, 16'sd2560, 12'd0, 4'd0}, 1, 1'b1,
			'{ST_STORED, 12'd4095, 4'd0, 4'd1, 16'sd0, 16'sd0, 16'sd0}},
		'{'{OP_ADD, -16'sd2560, -16'sd2560, -16'sd2560, 12'd4095, 4'd15}, 1, 1'b1,
			'{ST_STORED, 12'd0, 4'd0, 4'd1, 16'sd0, 16'sd0, 16'sd0}},
		'{'{OP_ADD, 16'sd2561, 16'sd0, 16'sd0, 12'd0, 4'd0}, 1, 1'b1,
			'{ST_OOB, 12'd0, 4'd0, 4'd0, 16'sd0, 16'sd0, 16'sd0}},
		'{'{OP_ADD, -16'sd32768, -16'sd32768, -16'sd32768, 12'd4095, 4'd15}, 1, 1'b1,
			'{ST_OOB, 12'd0, 4'd0, 4'd0, 16'sd0, 16'sd0, 16'sd0}},
		'{'{OP_READ, 16'sd32767, 16'sd32767, 16'sd32767, 12'd4095, 4'd0}, 1, 1'b1,
			'{ST_READ_OK, 12'd4095, 4'd0, 4'd1, 16'sd2560, 16'sd2560, 16'sd2560}},
		'{'{OP_READ, 16'sd0, 16'sd0, 16'sd0, 12'd4095, 4'd15}, 1, 1'b1,
			'{ST_READ_EMPTY, 12'd4095, 4'd15, 4'd1, 16'sd0, 16'sd0, 16'sd0}},
		'{'{OP_SPARE, 16'sd0, 16'sd0, 16'sd0, 12'd0, 4'd0}, 1, 1'b1,
			'{ST_READ_OK, 12'd0, 4'd0, 4'd1, -16'sd2560, -16'sd2560, -16'sd2560}},
		'{'{OP_READ, 16'sd0, 16'sd0, 16'sd0, 12'd0, 4'd1}, 1, 1'b1,
			'{ST_READ_EMPTY, 12'd0, 4'd1, 4'd1, 16'sd0, 16'sd0, 16'sd0}},
		'{'{OP_ADD, -16'sd2500, -16'sd2450, -16'sd2400, 12'd0, 4'd0}, 14, 1'b0, UNTYPED},
		'{'{OP_ADD, -16'sd2560, -16'sd2560, -16'sd2560, 12'd0, 4'd0}, 1, 1'b1,
			'{ST_FULL, 12'd0, 4'd0, 4'd15, 16'sd0, 16'sd0, 16'sd0}},
		'{'{OP_READ, 16'sd0, 16'sd0, 16'sd0, 12'd0, 4'd15}, 1, 1'b1,
			'{ST_READ_EMPTY, 12'd0, 4'd15, 4'd15, 16'sd0, 16'sd0, 16'sd0}},
		'{'{OP_READ, 16'sd0, 16'sd0, 16'sd0, 12'd0, 4'd14}, 1, 1'b0, UNTYPED},
		'{'{OP_CLEAR, -16'sd1, -16'sd1, -16'sd1, 12'd4095, 4'd15}, 1, 1'b1,
			'{ST_CLEARED, 12'd0, 4'd0, 4'd0, 16'sd0, 16'sd0, 16'sd0}},
		'{'{OP_READ, 16'sd0, 16'sd0, 16'sd0, 12'd0, 4'd0}, 1, 1'b1,
			'{ST_READ_EMPTY, 12'd0, 4'd0, 4'd0, 16'sd0, 16'sd0, 16'sd0}},
		'{'{OP_ADD, 16'sd2560, -16'sd2560, 16'sd0, 12'd0, 4'd0}, 1, 1'b0, UNTYPED}
	};

	// half x/y/z, scale x/y/z per phase
	int grid_plan [PHASES][6] = '{
		'{32767, 32767, 32767, 65535, 65535, 65535},
		'{0, 0, 0, 1, 1, 1},
		'{255, 255, 255, 4096, 4096, 4096},
		'{RANDOM_CFG, RANDOM_CFG, RANDOM_CFG, RANDOM_CFG, RANDOM_CFG, RANDOM_CFG},
		'{1000, 300, 20000, 0, 8192, 300},
		'{2560, 2560, 2560, 205, 205, 205},
		'{RANDOM_CFG, RANDOM_CFG, RANDOM_CFG, RANDOM_CFG, RANDOM_CFG, RANDOM_CFG}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int axis_bin(logic signed [COORD_W-1:0] c, logic [HALF_W-1:0] h,
			logic [SCALE_W-1:0] s, int cells);
		longint span;
		longint bin_no;
		span = longint'(c) + longint'(h);
		bin_no = (span * longint'(s)) >>> 16;
		if (bin_no >= cells)
			bin_no = cells - 1;
		return int'(bin_no);
	endfunction

	function automatic bit in_box(logic signed [COORD_W-1:0] c, logic [HALF_W-1:0] h);
		return int'(c) >= -int'(h) && int'(c) <= int'(h);
	endfunction

	function automatic bin_result_t bin_predict(bin_cmd_t c);
		bin_result_t r;
		int v;
		int n;
		int s;
		r = '0;
		case (c.op)
			OP_ADD: begin
				if (!in_box(c.x, half_ext[0]) || !in_box(c.y, half_ext[1]) ||
						!in_box(c.z, half_ext[2])) begin
					r.status = ST_OOB;
				end else begin
					v = axis_bin(c.x, half_ext[0], cell_scale[0], GRID_X) * GRID_Y * GRID_Z +
						axis_bin(c.y, half_ext[1], cell_scale[1], GRID_Y) * GRID_Z +
						axis_bin(c.z, half_ext[2], cell_scale[2], GRID_Z);
					n = int'(tally[v]);
					r.voxel = VSEL_W'(v);
					if (n >= MAX_POINTS - 1) begin
						r.status = ST_FULL;
						r.count = CNT_W'(n);
					end else begin
						obs_mem[v][n] = {c.x, c.y, c.z};
						tally[v] = CNT_W'(n + 1);
						r.status = ST_STORED;
						r.slot = SSEL_W'(n);
						r.count = CNT_W'(n + 1);
					end
					hit_voxels.insert(hit_voxels.size(), v);
					if (hit_voxels.size() > 16)
						void'(hit_voxels.pop_front());
				end
			end
			OP_CLEAR: begin
				foreach (tally[i])
					tally[i] = '0;
				r.status = ST_CLEARED;
			end
			default: begin
				v = int'(c.vsel);
				s = int'(c.ssel);
				r.voxel = c.vsel;
				r.slot = c.ssel;
				r.status = ST_READ_EMPTY;
				if (v < VOXELS) begin
					n = int'(tally[v]);
					r.count = CNT_W'(n);
					if (s < n && s < MAX_POINTS) begin
						r.status = ST_READ_OK;
						{r.x, r.y, r.z} = obs_mem[v][s];
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic void plant_hot_spots();
		int h;
		for (int i = 0; i < HOT_SPOTS; i++) begin
			for (int a = 0; a < 3; a++) begin
				h = int'(half_ext[a]);
				hot_spot[i][a] = int'($urandom_range(0, 2 * h)) - h;
			end
		end
	endfunction

	// adds (half on hot voxels, rest spread, boundary or raw noise), reads, clears
	function automatic bin_cmd_t draw_cmd();
		bin_cmd_t c;
		int pick;
		int kind;
		int hot;
		int h;
		int v;
		int pt [3];
		c.op = OP_ADD;
		c.vsel = VSEL_W'($urandom_range(0, (1 << VSEL_W) - 1));
		c.ssel = SSEL_W'($urandom_range(0, (1 << SSEL_W) - 1));
		pick = $urandom_range(0, 99);
		kind = $urandom_range(0, 19);
		hot = $urandom_range(0, HOT_SPOTS - 1);
		for (int a = 0; a < 3; a++) begin
			h = int'(half_ext[a]);
			if (pick >= 35 && kind < 10)
				v = hot_spot[hot][a] + int'($urandom_range(0, 2)) - 1;
			else if (pick >= 35 && kind < 15)
				v = int'($urandom_range(0, 2 * h)) - h;
			else if (pick >= 35 && kind < 17)
				v = ($urandom_range(0, 1) ? 1 : -1) * (h + int'($urandom_range(0, 1)));
			else
				v = int'($urandom_range(0, 65535));
			pt[a] = v;
		end
		c.x = pt[0][COORD_W-1:0];
		c.y = pt[1][COORD_W-1:0];
		c.z = pt[2][COORD_W-1:0];
		if (pick == 0) begin
			c.op = OP_CLEAR;
		end else if (pick < 35) begin
			c.op = ($urandom_range(0, 9) == 0) ? OP_SPARE : OP_READ;
			if (hit_voxels.size() != 0 && $urandom_range(0, 3) != 0)
				c.vsel = VSEL_W'(hit_voxels[$urandom_range(0, hit_voxels.size() - 1)]);
		end
		return c;
	endfunction

	// called at a clock edge; returns at the edge of the transfer
	task automatic issue(bin_cmd_t c, bit typed, bin_result_t typed_want);
		int gap;
		bin_result_t predicted;
		if ($urandom_range(0, 31) == 0)
			in_steady = !in_steady;
		gap = in_steady ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.operation    <= c.op;
		in_ch.coord_x      <= c.x;
		in_ch.coord_y      <= c.y;
		in_ch.coord_z      <= c.z;
		in_ch.voxel_select <= c.vsel;
		in_ch.slot_select  <= c.ssel;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		predicted = bin_predict(c);
		if (typed)
			predicted = typed_want;
		awaited_results.insert(awaited_results.size(), predicted);
	endtask

	task automatic set_grid(input int vals [6]);
		reg_idx_t order [6];
		order = '{REG_HALF_X, REG_HALF_Y, REG_HALF_Z, REG_SCALE_X, REG_SCALE_Y, REG_SCALE_Z};
		for (int i = 0; i < 6; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= vals[i][CFG_DATA_W-1:0];
			@(posedge clk);
			case (order[i])
				REG_HALF_X:  half_ext[0] = vals[i][HALF_W-1:0];
				REG_HALF_Y:  half_ext[1] = vals[i][HALF_W-1:0];
				REG_HALF_Z:  half_ext[2] = vals[i][HALF_W-1:0];
				REG_SCALE_X: cell_scale[0] = vals[i][SCALE_W-1:0];
				REG_SCALE_Y: cell_scale[1] = vals[i][SCALE_W-1:0];
				default:     cell_scale[2] = vals[i][SCALE_W-1:0];
			endcase
		end
		cfg_write <= 1'b0;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	initial begin : stimulus
		bin_cmd_t c;
		int grid_vals [6];
		foreach (tally[i])
			tally[i] = '0;
		for (int a = 0; a < 3; a++) begin
			half_ext[a] = HALF_RESET;
			cell_scale[a] = SCALE_RESET;
		end
		arst_n             <= 1'b0;
		cfg_write          <= 1'b0;
		cfg_index          <= '0;
		cfg_data           <= '0;
		in_ch.valid        <= 1'b0;
		in_ch.operation    <= '0;
		in_ch.coord_x      <= '0;
		in_ch.coord_y      <= '0;
		in_ch.coord_z      <= '0;
		in_ch.voxel_select <= '0;
		in_ch.slot_select  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[r]) begin
			for (int rep = 0; rep < opening[r].reps; rep++)
				issue(opening[r].cmd, opening[r].typed, opening[r].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			for (int i = 0; i < 6; i++) begin
				if (grid_plan[ph][i] != RANDOM_CFG)
					grid_vals[i] = grid_plan[ph][i];
				else if (i < 3)
					grid_vals[i] = $urandom_range(0, HALF_MAX);
				else
					grid_vals[i] = $urandom_range(1, SCALE_MAX);
			end
			set_grid(grid_vals);
			plant_hot_spots();
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 2 && k == 80)
					hold_request = HOLD_CYCLES;
				c = draw_cmd();
				issue(c, 1'b0, UNTYPED);
			end
		end

		in_ch.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("voxel_point_binning_test passed");
		else
			$display("voxel_point_binning_test failed");
		$finish;
	end

	initial begin : result_sink
		int gap;
		bit steady;
		bin_result_t got;
		bin_result_t want;
		steady = 0;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				steady = !steady;
			gap = steady ? 0 : $urandom_range(0, 13);
			if (hold_request > 0) begin
				gap = hold_request;
				hold_request = 0;
			end
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			got.status = status_t'(out_ch.status);
			got.voxel  = out_ch.voxel_index;
			got.slot   = out_ch.slot_index;
			got.count  = out_ch.point_count;
			got.x      = out_ch.out_x;
			got.y      = out_ch.out_y;
			got.z      = out_ch.out_z;
			if (awaited_results.size() == 0) begin
				$display("%0t: no result expected, got status %0h voxel %0h", $time,
					got.status, got.voxel);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				check_field("status", 16'(want.status), 16'(got.status));
				check_field("voxel_index", 16'(want.voxel), 16'(got.voxel));
				check_field("slot_index", 16'(want.slot), 16'(got.slot));
				check_field("point_count", 16'(want.count), 16'(got.count));
				check_field("out_x", want.x, got.x);
				check_field("out_y", want.y, got.y);
				check_field("out_z", want.z, got.z);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
					(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("voxel_point_binning_test failed");
		$finish;
	end

endmodule

### sim.f
hw/rtl/vpb_pkg.sv
hw/rtl/vpb_in_if.sv
hw/rtl/vpb_out_if.sv
hw/rtl/vpb_ram.sv
hw/rtl/vpb_axis.sv
hw/rtl/voxel_point_binning.sv
test/voxel_point_binning_test.sv
